@@ sv/rcsr_pkg.sv @@
`timescale 1ns / 1ps
// rcsr_pkg: shared types, codes and sizes of the reversed CSR builder.
// No dependencies; the interfaces, the builder and the checker import it.
package rcsr_pkg;

   localparam int MAX_NODES = 65536;
   localparam int MAX_EDGES = 65536;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int EDGE_W    = $clog2(MAX_EDGES);
   localparam int ARC_W     = EDGE_W + 1;
   localparam int CNT_W     = 18;
   localparam int NCNT_W    = 17;
   localparam int EDGE_MW   = 66;
   localparam int ARC_MW    = 48;

   localparam logic [2:0] OP_MAP_LOAD  = 3'd0;
   localparam logic [2:0] OP_EDGE_LOAD = 3'd1;
   localparam logic [2:0] OP_BUILD     = 3'd2;
   localparam logic [2:0] OP_RD_OFFSET = 3'd3;
   localparam logic [2:0] OP_RD_ARC    = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NOTBUILT = 3'd3;
   localparam logic [2:0] ST_INDEX    = 3'd4;

   localparam logic [3:0] REG_NODES_USED = 4'd0;
   localparam logic [3:0] REG_METRIC     = 4'd1;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [16:0]        position;
      logic [15:0]        spatial_id;
      logic [15:0]        edge_source;
      logic [15:0]        edge_target;
      logic               dir_forward;
      logic               dir_backward;
      logic signed [31:0] duration;
      logic signed [31:0] weight;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [17:0] value;
      logic [31:0] arc_cost;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  index;
      logic [16:0] data;
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_CLEAR,
      S_E_FETCH,
      S_E_SRC,
      S_E_TGT,
      S_E_CHK,
      S_E_ISSUE,
      S_E_UPDATE,
      S_P_RD,
      S_P_WR,
      S_DONE,
      S_FAIL
   } state_type;

endpackage

@@ sv/rcsr_if.sv @@
`timescale 1ns / 1ps
// rcsr channel interfaces: request, response and register write channels.
// Depends on rcsr_pkg for the payload types.
interface rcsr_req_if;
   import rcsr_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rcsr_rsp_if;
   import rcsr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rcsr_csr_if;
   import rcsr_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/rcsr_ram.sv @@
`timescale 1ns / 1ps
// rcsr_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module rcsr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ sv/reversed_csr_builder.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Modport  Transfer
// req_bus   in   sink     command: map load, edge load, build, read offset, read arc
// rsp_bus   out  source   one status/value/cost per command
// csr_bus   in   sink     register write: nodes in use, cost metric select
//
// Loads, unused opcodes and reads answered without a memory access (unbuilt, out of
// range, the offset at index n) respond from idle; other offset and arc reads go through
// S_READ. Build: clear the n counts, count each edge (fetch and map it, then update each
// direction it has), prefix-sum the counts, scatter the edges the same way, respond;
// a stale build stops at the first bad edge. One command is in flight at a time.
// Reset clears control and registers only; memories are written before use.
// A response waiting on rsp_bus holds off the next command until it transfers.
module reversed_csr_builder (
   input  logic       clock,
   input  logic       reset,
   rcsr_req_if.sink   req_bus,
   rcsr_rsp_if.source rsp_bus,
   rcsr_csr_if.sink   csr_bus
);
   import rcsr_pkg::*;

   state_type state_ff, state_in;

   logic [NCNT_W-1:0] nodes_used_ff, nodes_used_in;
   logic              metric_ff, metric_in;
   logic              built_ff, built_in;
   logic [EDGE_W:0]   edges_loaded_ff, edges_loaded_in;
   logic [CNT_W-1:0]  arc_total_ff, arc_total_in;
   logic              read_arc_ff, read_arc_in;
   logic [NCNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic              scatter_ff, scatter_in;
   logic              dir_ff, dir_in;
   logic [15:0]       t_ff, t_in, ms_ff, ms_in, mt_ff, mt_in;
   logic              fwd_ff, fwd_in, bwd_ff, bwd_in;
   logic [31:0]       cost_ff, cost_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [NCNT_W-1:0] n_nodes;
   logic              accept, csr_accept;
   req_type           rq;
   logic              map_bad, edge_bad, edge_full;
   logic [31:0]       raw_cost, new_cost;
   logic              idx_last_node, idx_last_edge;
   logic [15:0]       node_sel, other_sel;

   // memory ports
   logic                 map_we, map_re;
   logic [NODE_W-1:0]    map_wa, map_ra;
   logic [15:0]          map_wd, map_rd;
   logic                 edge_we, edge_re;
   logic [EDGE_W-1:0]    edge_wa, edge_ra;
   logic [EDGE_MW-1:0]   edge_wd, edge_rd;
   logic                 off_we, off_re;
   logic [NODE_W-1:0]    off_wa, off_ra;
   logic [CNT_W-1:0]     off_wd, off_rd;
   logic                 cur_we, cur_re;
   logic [NODE_W-1:0]    cur_wa, cur_ra;
   logic [CNT_W-1:0]     cur_wd, cur_rd;
   logic                 arc_we, arc_re;
   logic [ARC_W-1:0]     arc_wa, arc_ra;
   logic [ARC_MW-1:0]    arc_wd, arc_rd;

   assign n_nodes = (nodes_used_ff > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
                                                         : nodes_used_ff;
   assign rq         = req_bus.data;
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept     = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_accept = csr_bus.valid;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

   assign map_bad   = (rq.position >= n_nodes) || ({1'b0, rq.spatial_id} >= n_nodes);
   assign edge_bad  = ({1'b0, rq.edge_source} >= n_nodes)
                   || ({1'b0, rq.edge_target} >= n_nodes);
   assign edge_full = (edges_loaded_ff == (EDGE_W+1)'(MAX_EDGES));
   assign raw_cost  = metric_ff ? rq.duration : rq.weight;
   assign new_cost  = raw_cost[31] ? 32'd0 : raw_cost;

   assign idx_last_node = ((idx_ff + 1'b1) == n_nodes);
   assign idx_last_edge = ({1'b0, idx_ff[EDGE_W:0]} + 1'b1) == {1'b0, edges_loaded_ff};
   assign node_sel  = dir_ff ? ms_ff : mt_ff;
   assign other_sel = dir_ff ? mt_ff : ms_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (rq.opcode == OP_BUILD) begin
                  if (n_nodes != '0) state_in = S_CLEAR;
                  else if (edges_loaded_ff != '0) state_in = S_E_FETCH;
                  else state_in = S_DONE;
               end else if (rq.opcode == OP_RD_OFFSET && built_ff
                            && rq.position < n_nodes) begin
                  state_in = S_READ;
               end else if (rq.opcode == OP_RD_ARC && built_ff
                            && {1'b0, rq.position} < arc_total_ff) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: state_in = S_IDLE;
         S_CLEAR: begin
            if (idx_last_node) begin
               state_in = (edges_loaded_ff != '0) ? S_E_FETCH : S_P_RD;
            end
         end
         S_E_FETCH: state_in = S_E_SRC;
         S_E_SRC: begin
            if ({1'b0, edge_rd[47:32]} >= n_nodes || {1'b0, edge_rd[63:48]} >= n_nodes)
               state_in = S_FAIL;
            else
               state_in = S_E_TGT;
         end
         S_E_TGT: state_in = S_E_CHK;
         S_E_CHK: begin
            priority if (!scatter_ff && ({1'b0, ms_ff} >= n_nodes
                                         || {1'b0, map_rd} >= n_nodes)) begin
               state_in = S_FAIL;
            end else if (fwd_ff || bwd_ff) begin
               state_in = S_E_ISSUE;
            end else if (!idx_last_edge) begin
               state_in = S_E_FETCH;
            end else begin
               state_in = scatter_ff ? S_DONE : S_P_RD;
            end
         end
         S_E_ISSUE: state_in = S_E_UPDATE;
         S_E_UPDATE: begin
            priority if (!dir_ff && bwd_ff) state_in = S_E_ISSUE;
            else if (!idx_last_edge) state_in = S_E_FETCH;
            else state_in = scatter_ff ? S_DONE : S_P_RD;
         end
         S_P_RD: state_in = S_P_WR;
         S_P_WR: begin
            if (idx_last_node) begin
               state_in = (edges_loaded_ff != '0) ? S_E_FETCH : S_DONE;
            end else begin
               state_in = S_P_RD;
            end
         end
         S_DONE: state_in = S_IDLE;
         S_FAIL: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      map_we = 1'b0; map_wa = rq.position[NODE_W-1:0]; map_wd = rq.spatial_id;
      map_re = 1'b0; map_ra = edge_rd[32+NODE_W-1:32];
      edge_we = 1'b0; edge_wa = edges_loaded_ff[EDGE_W-1:0];
      edge_wd = {rq.dir_backward, rq.dir_forward, rq.edge_target, rq.edge_source, new_cost};
      edge_re = 1'b0; edge_ra = idx_ff[EDGE_W-1:0];
      off_we = 1'b0; off_wa = idx_ff[NODE_W-1:0]; off_wd = '0;
      off_re = 1'b0; off_ra = idx_ff[NODE_W-1:0];
      cur_we = 1'b0; cur_wa = idx_ff[NODE_W-1:0]; cur_wd = acc_ff;
      cur_re = 1'b0; cur_ra = node_sel[NODE_W-1:0];
      arc_we = 1'b0; arc_wa = cur_rd[ARC_W-1:0]; arc_wd = {other_sel, cost_ff};
      arc_re = 1'b0; arc_ra = rq.position[ARC_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               map_we  = (rq.opcode == OP_MAP_LOAD) && !map_bad;
               edge_we = (rq.opcode == OP_EDGE_LOAD) && !edge_bad && !edge_full;
               off_re  = (rq.opcode == OP_RD_OFFSET);
               off_ra  = rq.position[NODE_W-1:0];
               arc_re  = (rq.opcode == OP_RD_ARC);
            end
         end
         S_CLEAR: off_we = 1'b1;
         S_E_FETCH: edge_re = 1'b1;
         S_E_SRC: map_re = 1'b1;
         S_E_TGT: begin
            map_re = 1'b1;
            map_ra = t_ff[NODE_W-1:0];
         end
         S_E_ISSUE: begin
            off_re = !scatter_ff;
            off_ra = node_sel[NODE_W-1:0];
            cur_re = scatter_ff;
         end
         S_E_UPDATE: begin
            off_we = !scatter_ff;
            off_wa = node_sel[NODE_W-1:0];
            off_wd = off_rd + 1'b1;
            cur_we = scatter_ff;
            cur_wa = node_sel[NODE_W-1:0];
            cur_wd = cur_rd + 1'b1;
            arc_we = scatter_ff;
         end
         S_P_RD: off_re = 1'b1;
         S_P_WR: begin
            off_we = 1'b1;
            off_wd = acc_ff;
            cur_we = 1'b1;
         end
         default: ;
      endcase
   end

   // datapath and response
   always_comb begin
      nodes_used_in   = nodes_used_ff;
      metric_in       = metric_ff;
      built_in        = built_ff;
      edges_loaded_in = edges_loaded_ff;
      arc_total_in    = arc_total_ff;
      read_arc_in     = read_arc_ff;
      idx_in          = idx_ff;
      acc_in          = acc_ff;
      scatter_in      = scatter_ff;
      dir_in          = dir_ff;
      t_in = t_ff; ms_in = ms_ff; mt_in = mt_ff;
      fwd_in = fwd_ff; bwd_in = bwd_ff; cost_in = cost_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_in          = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = '{status: ST_OK, value: '0, arc_cost: '0};
               rsp_valid_in = 1'b1;
               unique case (rq.opcode)
                  OP_MAP_LOAD: begin
                     if (map_bad) rsp_in.status = ST_RANGE;
                     else begin
                        rsp_in.value = {2'b00, rq.spatial_id};
                        built_in = 1'b0;
                     end
                  end
                  OP_EDGE_LOAD: begin
                     priority if (edge_bad) rsp_in.status = ST_RANGE;
                     else if (edge_full) rsp_in.status = ST_FULL;
                     else begin
                        edges_loaded_in = edges_loaded_ff + 1'b1;
                        rsp_in.value = CNT_W'(edges_loaded_ff) + 1'b1;
                        built_in = 1'b0;
                     end
                  end
                  OP_BUILD: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                     rsp_in       = rsp_ff;
                     built_in     = 1'b0;
                     arc_total_in = '0;
                     idx_in       = '0;
                     acc_in       = '0;
                     scatter_in   = 1'b0;
                  end
                  OP_RD_OFFSET: begin
                     priority if (!built_ff) rsp_in.status = ST_NOTBUILT;
                     else if (rq.position > n_nodes) rsp_in.status = ST_INDEX;
                     else if (rq.position == n_nodes) rsp_in.value = arc_total_ff;
                     else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                        rsp_in       = rsp_ff;
                        read_arc_in  = 1'b0;
                     end
                  end
                  OP_RD_ARC: begin
                     priority if (!built_ff) rsp_in.status = ST_NOTBUILT;
                     else if ({1'b0, rq.position} >= arc_total_ff)
                        rsp_in.status = ST_INDEX;
                     else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                        rsp_in       = rsp_ff;
                        read_arc_in  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = ST_OK;
            if (read_arc_ff) begin
               rsp_in.value    = {2'b00, arc_rd[47:32]};
               rsp_in.arc_cost = arc_rd[31:0];
            end else begin
               rsp_in.value    = off_rd;
               rsp_in.arc_cost = '0;
            end
         end
         S_CLEAR: idx_in = idx_last_node ? '0 : idx_ff + 1'b1;
         S_E_SRC: begin
            cost_in = edge_rd[31:0];
            t_in    = edge_rd[63:48];
            fwd_in  = edge_rd[64];
            bwd_in  = edge_rd[65];
         end
         S_E_TGT: ms_in = map_rd;
         S_E_CHK: begin
            mt_in  = map_rd;
            dir_in = !fwd_ff;
            if (!fwd_ff && !bwd_ff) idx_in = idx_last_edge ? '0 : idx_ff + 1'b1;
         end
         S_E_UPDATE: begin
            if (!dir_ff && bwd_ff) dir_in = 1'b1;
            else idx_in = idx_last_edge ? '0 : idx_ff + 1'b1;
         end
         S_P_WR: begin
            acc_in = acc_ff + off_rd;
            idx_in = idx_last_node ? '0 : idx_ff + 1'b1;
            if (idx_last_node) begin
               arc_total_in = acc_ff + off_rd;
               scatter_in   = 1'b1;
            end
         end
         S_DONE: begin
            built_in     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_OK, value: arc_total_ff, arc_cost: '0};
         end
         S_FAIL: begin
            built_in     = 1'b0;
            arc_total_in = '0;
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_RANGE, value: '0, arc_cost: '0};
         end
         default: ;
      endcase

      if (csr_accept) begin
         if (csr_bus.data.index == REG_NODES_USED) begin
            nodes_used_in = csr_bus.data.data;
            built_in      = 1'b0;
         end else if (csr_bus.data.index == REG_METRIC) begin
            metric_in = csr_bus.data.data[0];
            built_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         nodes_used_ff   <= NCNT_W'(MAX_NODES);
         metric_ff       <= 1'b1;
         built_ff        <= 1'b0;
         edges_loaded_ff <= '0;
         arc_total_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         idx_ff          <= '0;
         scatter_ff      <= 1'b0;
         dir_ff          <= 1'b0;
         read_arc_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         nodes_used_ff   <= nodes_used_in;
         metric_ff       <= metric_in;
         built_ff        <= built_in;
         edges_loaded_ff <= edges_loaded_in;
         arc_total_ff    <= arc_total_in;
         rsp_valid_ff    <= rsp_valid_in;
         idx_ff          <= idx_in;
         scatter_ff      <= scatter_in;
         dir_ff          <= dir_in;
         read_arc_ff     <= read_arc_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      ms_ff   <= ms_in;
      mt_ff   <= mt_in;
      fwd_ff  <= fwd_in;
      bwd_ff  <= bwd_in;
      cost_ff <= cost_in;
      rsp_ff  <= rsp_in;
   end

   rcsr_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_node_map (
      .clock, .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_en(map_re), .rd_addr(map_ra), .rd_data(map_rd));

   rcsr_ram #(.WIDTH(EDGE_MW), .DEPTH(MAX_EDGES)) u_edge_mem (
      .clock, .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_en(edge_re), .rd_addr(edge_ra), .rd_data(edge_rd));

   // per-node counts during build, offsets afterwards
   rcsr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_offset_mem (
      .clock, .wr_en(off_we), .wr_addr(off_wa), .wr_data(off_wd),
      .rd_en(off_re), .rd_addr(off_ra), .rd_data(off_rd));

   rcsr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_cursor_mem (
      .clock, .wr_en(cur_we), .wr_addr(cur_wa), .wr_data(cur_wd),
      .rd_en(cur_re), .rd_addr(cur_ra), .rd_data(cur_rd));

   rcsr_ram #(.WIDTH(ARC_MW), .DEPTH(2 * MAX_EDGES)) u_arc_mem (
      .clock, .wr_en(arc_we), .wr_addr(arc_wa), .wr_data(arc_wd),
      .rd_en(arc_re), .rd_addr(arc_ra), .rd_data(arc_rd));

endmodule

@@ sv/rcsr_checker.sv @@
`timescale 1ns / 1ps
// rcsr_checker: port-level checks of the reversed CSR builder response channel.
// Depends on rcsr_pkg; bound to reversed_csr_builder below.
module rcsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [17:0] rsp_value,
   input logic [31:0] rsp_cost
);
   import rcsr_pkg::*;

   // no response may appear right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == '0 && rsp_cost == '0)
      else $error("error response carries data");

   // costs are clamped non-negative
   a_cost_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_cost[31])
      else $error("negative arc cost");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_value) && $stable(rsp_cost))
      else $error("stalled response changed");
endmodule

bind reversed_csr_builder rcsr_checker u_rcsr_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_status(rsp_bus.data.status),
   .rsp_value(rsp_bus.data.value),
   .rsp_cost(rsp_bus.data.arc_cost)
);
